// File: src/mrtm_pkg.sv
`default_nettype none

package mrtm_pkg;

    localparam int RESP_BYTES_DEF = 72;
    localparam int MAX_WORDS      = 33;
    localparam int CNT_W          = 7;
    localparam int WORD_W         = 6;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  FC_READ_HOLD = 8'h03;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
    localparam logic [15:0] TIMEOUT_RST    = 16'd500;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_RX    = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CRC_ERR  = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_RECV = 1'b1
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_REQ_CRC,
        S_REQ_WAIT,
        S_REQ_EMIT,
        S_RX_WAIT,
        S_CHK_RD,
        S_CHK,
        S_W_RDH,
        S_W_RDL,
        S_W_EMIT,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic       init;
        logic       start;
        logic [7:0] data;
    } t_crc_ctrl;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } t_crc_stat;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] timeout_ms;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/mrtm_ram.sv
`default_nettype none

module mrtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 72
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/mrtm_crc.sv
`default_nettype none

module mrtm_crc (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire mrtm_pkg::t_crc_ctrl i_ctrl,
    output mrtm_pkg::t_crc_stat  o_stat
);

    import mrtm_pkg::*;

    logic [15:0] r_crc;
    logic        r_busy;
    logic [2:0]  r_bit;

    // one polynomial step per cycle, eight steps per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (i_ctrl.init) begin
            r_crc  <= CRC_INIT;
            r_busy <= 1'b0;
        end else if (i_ctrl.start) begin
            r_crc  <= r_crc ^ {8'h00, i_ctrl.data};
            r_busy <= 1'b1;
            r_bit  <= '0;
        end else if (r_busy) begin
            r_crc <= (r_crc >> 1) ^ (r_crc[0] ? CRC_POLY : 16'h0000);
            r_bit <= r_bit + 3'd1;
            if (r_bit == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.crc  = r_crc;

endmodule

`default_nettype wire

// File: src/mrtm_cfg.sv
`default_nettype none

module mrtm_cfg (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [mrtm_pkg::PADDR_W-1:0]    paddr,
    input  wire [mrtm_pkg::PDATA_W-1:0]    pwdata,
    output logic [mrtm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output mrtm_pkg::t_cfg                 o_cfg
);

    import mrtm_pkg::*;

    logic [7:0]  r_slave_address;
    logic [15:0] r_timeout_ms;
    logic        w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= SLAVE_ADDR_RST;
            r_timeout_ms    <= TIMEOUT_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SLAVE_ADDR: r_slave_address <= pwdata[7:0];
                REG_TIMEOUT:    r_timeout_ms    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SLAVE_ADDR: prdata = {24'h0, r_slave_address};
            REG_TIMEOUT:    prdata = {16'h0, r_timeout_ms};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.slave_address = r_slave_address;
    assign o_cfg.timeout_ms    = r_timeout_ms;

endmodule

`default_nettype wire

// File: src/modbus_read_transaction_master.sv
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+------------------------------------------
// input     | i_in_valid / o_in_stall       | i_mode i_start_reg i_reg_count i_rx_byte
// output    | o_out_valid / i_out_stall     | o_kind o_tx_byte o_reg_index o_reg_value
//           |                               | o_status o_last
// config    | APB psel penable pwrite       | paddr pwdata prdata pready
//
// One transaction in flight; o_in_stall is high whenever the sequencer is not idle.
// Start: dispatch, then six request bytes through the bit-serial CRC unit in turn,
// then 8 loads; a too-long start goes from dispatch to a single status load.
// Received byte: stored and fed to the bit-serial CRC unit, which holds the sequencer;
// the first CRC byte is only stored; the final byte starts the check, then two reads
// per word (one RAM read port), or a status. Tick or stray item: status on a timeout.
// Output stalls hold the sequencer; the response RAM is not cleared.
// Reset is synchronous, active low.
`default_nettype none

module modbus_read_transaction_master #(
    parameter int RESP_BYTES = mrtm_pkg::RESP_BYTES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [1:0]                    i_mode,
    input  wire [15:0]                   i_start_reg,
    input  wire [15:0]                   i_reg_count,
    input  wire [7:0]                    i_rx_byte,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_tx_byte,
    output logic [5:0]                   o_reg_index,
    output logic [15:0]                  o_reg_value,
    output logic [1:0]                   o_status,
    output logic                         o_last,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [mrtm_pkg::PADDR_W-1:0]  paddr,
    input  wire [mrtm_pkg::PDATA_W-1:0]  pwdata,
    output logic [mrtm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import mrtm_pkg::*;

    localparam int AW = $clog2(RESP_BYTES);

    t_cfg      w_cfg;
    t_crc_ctrl w_crc_ctrl;
    t_crc_stat w_crc_stat;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_exp, n_exp;
    logic [CNT_W-1:0]    r_rcvd, n_rcvd;
    logic [15:0]         r_elapsed, n_elapsed;
    logic [WORD_W-1:0]   r_words, n_words;
    logic [WORD_W-1:0]   r_widx, n_widx;
    logic [2:0]          r_idx, n_idx;
    logic [7:0]          r_hi, n_hi;
    t_status             r_status, n_status;

    logic [1:0]          r_mode;
    logic [15:0]         r_start_reg;
    logic [15:0]         r_cnt_in;
    logic [7:0]          r_rx_byte;

    logic                w_in_acc;
    logic                w_out_free;
    logic [17:0]         w_exp_full;
    logic                w_too_long;
    logic                w_rx_room;
    logic                w_rx_crc;
    logic                w_rx_final;
    logic [7:0]          w_frame_byte;
    logic [CNT_W-1:0]    w_raddr_full;
    logic                w_ram_re;
    logic                w_ram_we;
    logic [7:0]          w_rdata;
    logic                w_word_last;

    logic                w_load;
    t_kind               w_ld_kind;
    logic [7:0]          w_ld_tx;
    logic [5:0]          w_ld_idx;
    logic [15:0]         w_ld_val;
    t_status             w_ld_status;
    logic                w_ld_last;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [7:0]          r_tx_byte;
    logic [5:0]          r_reg_index;
    logic [15:0]         r_reg_value;
    t_status             r_out_status;
    logic                r_last;

    mrtm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mrtm_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_crc_ctrl),
        .o_stat  (w_crc_stat)
    );

    mrtm_ram #(
        .WIDTH (8),
        .DEPTH (RESP_BYTES)
    ) u_resp_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(r_rcvd)),
        .i_wdata (r_rx_byte),
        .i_re    (w_ram_re),
        .i_raddr (AW'(w_raddr_full)),
        .o_rdata (w_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_exp_full = {1'b0, r_cnt_in, 1'b0} + 18'd5;
    assign w_too_long = (r_cnt_in > 16'(MAX_WORDS)) || (w_exp_full > 18'(RESP_BYTES));
    assign w_rx_room  = (r_rcvd < r_exp) && (9'(r_rcvd) < 9'(RESP_BYTES));
    assign w_rx_crc   = ({1'b0, r_rcvd} + 8'd2) < {1'b0, r_exp};
    assign w_rx_final = (r_rcvd + 7'd1) == r_exp;
    assign w_word_last = (r_widx + 6'd1) == r_words;

    always_comb begin
        case (r_idx)
            3'd0: w_frame_byte = w_cfg.slave_address;
            3'd1: w_frame_byte = FC_READ_HOLD;
            3'd2: w_frame_byte = r_start_reg[15:8];
            3'd3: w_frame_byte = r_start_reg[7:0];
            3'd4: w_frame_byte = r_cnt_in[15:8];
            3'd5: w_frame_byte = r_cnt_in[7:0];
            3'd6: w_frame_byte = w_crc_stat.crc[7:0];
            3'd7: w_frame_byte = w_crc_stat.crc[15:8];
        endcase
    end

    always_comb begin
        w_ram_re     = 1'b1;
        w_raddr_full = '0;
        unique case (r_state)
            S_CHK_RD: w_raddr_full = r_exp - 7'd2;
            S_W_RDH:  w_raddr_full = 7'd3 + {r_widx, 1'b0};
            S_W_RDL:  w_raddr_full = 7'd4 + {r_widx, 1'b0};
            default:  w_ram_re     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_exp     <= '0;
            r_rcvd    <= '0;
            r_elapsed <= '0;
            r_words   <= '0;
            r_widx    <= '0;
            r_idx     <= '0;
            r_status  <= ST_OK;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_exp     <= n_exp;
            r_rcvd    <= n_rcvd;
            r_elapsed <= n_elapsed;
            r_words   <= n_words;
            r_widx    <= n_widx;
            r_idx     <= n_idx;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        if (w_in_acc) begin
            r_mode      <= i_mode;
            r_start_reg <= i_start_reg;
            r_cnt_in    <= i_reg_count;
            r_rx_byte   <= i_rx_byte;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_exp       = r_exp;
        n_rcvd      = r_rcvd;
        n_elapsed   = r_elapsed;
        n_words     = r_words;
        n_widx      = r_widx;
        n_idx       = r_idx;
        n_hi        = r_hi;
        n_status    = r_status;
        w_crc_ctrl  = '{init: 1'b0, start: 1'b0, data: w_frame_byte};
        w_ram_we    = 1'b0;
        w_load      = 1'b0;
        w_ld_kind   = KIND_STATUS;
        w_ld_tx     = '0;
        w_ld_idx    = '0;
        w_ld_val    = '0;
        w_ld_status = ST_OK;
        w_ld_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                case (r_mode)
                    MODE_START: begin
                        n_phase = PH_IDLE;
                        if (w_too_long) begin
                            n_status = ST_TOO_LONG;
                            n_state  = S_STATUS;
                        end else begin
                            w_crc_ctrl.init = 1'b1;
                            n_idx   = '0;
                            n_exp   = w_exp_full[CNT_W-1:0];
                            n_words = r_cnt_in[WORD_W-1:0];
                            n_state = S_REQ_CRC;
                        end
                    end
                    MODE_RX: begin
                        if (r_phase == PH_RECV) begin
                            if (!w_rx_room) begin
                                n_phase = PH_IDLE;
                            end else begin
                                w_ram_we = 1'b1;
                                n_rcvd   = r_rcvd + 7'd1;
                                if (w_rx_crc) begin
                                    w_crc_ctrl.start = 1'b1;
                                    w_crc_ctrl.data  = r_rx_byte;
                                    n_state = S_RX_WAIT;
                                end else if (w_rx_final) begin
                                    n_phase = PH_IDLE;
                                    n_state = S_CHK_RD;
                                end
                            end
                        end
                    end
                    MODE_TICK: begin
                        if (r_phase == PH_RECV) begin
                            n_elapsed = r_elapsed + 16'd1;
                            if (n_elapsed >= w_cfg.timeout_ms) begin
                                n_phase  = PH_IDLE;
                                n_status = ST_TIMEOUT;
                                n_state  = S_STATUS;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_REQ_CRC: begin
                w_crc_ctrl.start = 1'b1;
                n_state = S_REQ_WAIT;
            end
            S_REQ_WAIT: begin
                if (!w_crc_stat.busy) begin
                    if (r_idx == 3'd5) begin
                        n_idx   = '0;
                        n_state = S_REQ_EMIT;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = S_REQ_CRC;
                    end
                end
            end
            S_REQ_EMIT: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_kind = KIND_TX;
                    w_ld_tx   = w_frame_byte;
                    w_ld_last = (r_idx == 3'd7);
                    if (r_idx == 3'd7) begin
                        w_crc_ctrl.init = 1'b1;
                        n_phase   = PH_RECV;
                        n_rcvd    = '0;
                        n_elapsed = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            S_RX_WAIT: begin
                if (!w_crc_stat.busy) begin
                    n_state = S_IDLE;
                end
            end
            S_CHK_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if ({r_rx_byte, w_rdata} != w_crc_stat.crc) begin
                    n_status = ST_CRC_ERR;
                    n_state  = S_STATUS;
                end else if (r_words == '0) begin
                    n_status = ST_OK;
                    n_state  = S_STATUS;
                end else begin
                    n_widx  = '0;
                    n_state = S_W_RDH;
                end
            end
            S_W_RDH: begin
                n_state = S_W_RDL;
            end
            S_W_RDL: begin
                n_hi    = w_rdata;
                n_state = S_W_EMIT;
            end
            S_W_EMIT: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_kind = KIND_WORD;
                    w_ld_idx  = r_widx;
                    w_ld_val  = {r_hi, w_rdata};
                    w_ld_last = w_word_last;
                    if (w_word_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_widx  = r_widx + 6'd1;
                        n_state = S_W_RDH;
                    end
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_ld_kind   = KIND_STATUS;
                    w_ld_status = r_status;
                    w_ld_last   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind       <= w_ld_kind;
            r_tx_byte    <= w_ld_tx;
            r_reg_index  <= w_ld_idx;
            r_reg_value  <= w_ld_val;
            r_out_status <= w_ld_status;
            r_last       <= w_ld_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx_byte;
    assign o_reg_index = r_reg_index;
    assign o_reg_value = r_reg_value;
    assign o_status    = r_out_status;
    assign o_last      = r_last;

endmodule

`default_nettype wire
